// ===== design/command_line_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokenizer.
// Each macro is one labeled concurrent assertion that is clocked on the rising
// edge and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Types, constants and helper functions shared by the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

   localparam int LINE_MAX_DEFAULT = 64;

   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [6:0] SLOT_MAX = 7'd127;

   typedef enum logic [1:0] {
      KIND_ARG  = 2'd0,
      KIND_PIPE = 2'd1,
      KIND_END  = 2'd2
   } entry_kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_final;
   } req_item_type;

   typedef struct packed {
      entry_kind_type entry_kind;
      logic [5:0]     position;
      logic [6:0]     slot;
      logic           run_end;
   } rsp_entry_type;

   // Entries produced by one character, first entry in e0.
   typedef struct packed {
      logic [1:0]    count;
      logic          line_done;
      rsp_entry_type e0;
      rsp_entry_type e1;
   } scan_result_type;

   typedef struct packed {
      logic line_start;
   } scan_status_type;

   typedef struct packed {
      logic [1:0] count;
      logic       load_ok;
   } queue_status_type;

   function automatic logic [6:0] slot_inc(input logic [6:0] s);
      return (s == SLOT_MAX) ? s : s + 7'd1;
   endfunction

endpackage

// ===== design/clt_req_if.sv =====
// ----------------------------------------------------------------------------
// clt_req_if
// Character channel: one byte of the command line and a final flag.
// ----------------------------------------------------------------------------
interface clt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_final;

   modport source(output valid, output ch, output is_final, input ready);
   modport sink(input valid, input ch, input is_final, output ready);
endinterface

// ===== design/clt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// clt_rsp_if
// Entry channel: one argument list entry per transaction.
// ----------------------------------------------------------------------------
interface clt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] entry_kind;
   logic [5:0] position;
   logic [6:0] slot;
   logic       run_end;

   modport source(output valid, output entry_kind, output position, output slot,
                  output run_end, input ready);
   modport sink(input valid, input entry_kind, input position, input slot,
                input run_end, output ready);
endinterface

// ===== design/clt_req_stage.sv =====
// ----------------------------------------------------------------------------
// clt_req_stage
// Input register that holds one character until the scanner consumes it.
// ----------------------------------------------------------------------------
module clt_req_stage
   import clt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_ready,
   input  logic         advance,
   output logic         held_valid,
   output req_item_type held_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ===== design/clt_scan.sv =====
// ----------------------------------------------------------------------------
// clt_scan
// Line state and per-character entry generation.
// ----------------------------------------------------------------------------
module clt_scan
   import clt_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_item_type    item,
   output scan_result_type result,
   output scan_status_type status
);

   localparam int CP_W = $clog2(LINE_MAX);
   localparam logic [CP_W-1:0] LAST_POS = CP_W'(LINE_MAX - 1);

   logic [CP_W-1:0] pos_ff, pos_in;
   logic [6:0]      count_ff, count_in;
   logic            in_run_ff, in_run_in;
   logic            pipe_seen_ff, pipe_seen_in;

   logic          is_pipe, is_sep, at_start, fin, arg_hit, pipe_hit;
   logic [8:0]    pos9, end9;
   logic [6:0]    slot1, slot2;
   logic [1:0]    n_entries;
   rsp_entry_type first, second;

   always_comb begin
      is_pipe   = (item.ch == CH_PIPE);
      is_sep    = is_pipe || (item.ch == CH_SPACE);
      at_start  = (pos_ff == '0);
      fin       = item.is_final || (pos_ff == LAST_POS);
      arg_hit   = at_start || (!is_sep && in_run_ff);
      pipe_hit  = is_pipe && !pipe_seen_ff && !fin;
      n_entries = {1'b0, arg_hit} + {1'b0, pipe_hit} + {1'b0, fin};
      pos9      = 9'(pos_ff);
      end9      = pos9 + 9'd1;
      slot1     = slot_inc(count_ff);
      slot2     = slot_inc(slot1);

      // Entries come out in the order argument start, pipe marker, end.
      first.slot    = count_ff;
      first.run_end = (n_entries == 2'd1);
      if (arg_hit) begin
         first.entry_kind = KIND_ARG;
         first.position   = pos9[5:0];
      end else if (pipe_hit) begin
         first.entry_kind = KIND_PIPE;
         first.position   = pos9[5:0];
      end else begin
         first.entry_kind = KIND_END;
         first.position   = end9[5:0];
      end

      second.slot    = slot1;
      second.run_end = 1'b1;
      if (arg_hit && pipe_hit) begin
         second.entry_kind = KIND_PIPE;
         second.position   = pos9[5:0];
      end else begin
         second.entry_kind = KIND_END;
         second.position   = end9[5:0];
      end

      result.count     = n_entries;
      result.line_done = fin;
      result.e0        = first;
      result.e1        = second;
      status.line_start = at_start;
   end

   always_comb begin
      pos_in       = pos_ff;
      count_in     = count_ff;
      in_run_in    = in_run_ff;
      pipe_seen_in = pipe_seen_ff;
      if (advance) begin
         if (fin) begin
            pos_in       = '0;
            count_in     = '0;
            in_run_in    = 1'b0;
            pipe_seen_in = 1'b0;
         end else begin
            pos_in       = pos_ff + CP_W'(1);
            in_run_in    = is_sep;
            pipe_seen_in = is_sep && (pipe_seen_ff || is_pipe);
            case (n_entries)
               2'd0:    count_in = count_ff;
               2'd1:    count_in = slot1;
               default: count_in = slot2;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         in_run_ff    <= 1'b0;
         pipe_seen_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         in_run_ff    <= in_run_in;
         pipe_seen_ff <= pipe_seen_in;
      end
   end

endmodule

// ===== design/clt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// clt_rsp_queue
// Two-entry result register that presents entries one per transaction.
// ----------------------------------------------------------------------------
module clt_rsp_queue
   import clt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  scan_result_type  result,
   input  logic             rsp_ready,
   output logic             head_valid,
   output rsp_entry_type    head,
   output queue_status_type status
);

   logic [1:0]    count_ff, count_in;
   rsp_entry_type e0_ff, e0_in;
   rsp_entry_type e1_ff, e1_in;
   logic          pop;

   assign head_valid     = (count_ff != 2'd0);
   assign head           = e0_ff;
   assign pop            = head_valid && rsp_ready;
   assign status.count   = count_ff;
   // A new group fits when the queue is empty or its last entry leaves now.
   assign status.load_ok = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      if (load) begin
         count_in = result.count;
         e0_in    = result.e0;
         e1_in    = result.e1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         e0_in    = e1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

// ===== design/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Streaming splitter that turns a command line, one byte per transaction,
// into argument start, pipe marker and end-of-list entries.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                                  Transaction
//   req_chan   in         ch[7:0], is_final                         one character
//   rsp_chan   out        entry_kind[1:0], position[5:0],           one entry
//                         slot[6:0], run_end
//
// A character is taken in every cycle while each character yields at most one
// entry and rsp_chan does not stall; a character with two entries holds off
// the next character while its second entry leaves. Each character goes from
// the input register through the result queue to rsp_chan. Synchronous reset
// clears the line state and the valid flags of both register stages. A stall
// on rsp_chan backs up through the result queue into the input register.
//
module command_line_tokenizer
   import clt_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
   input logic        clock,
   input logic        reset,
   clt_req_if.sink    req_chan,
   clt_rsp_if.source  rsp_chan
);

   `include "command_line_tokenizer_assert.svh"

   req_item_type     req_item;
   logic             held_valid;
   req_item_type     held_item;
   logic             consume;
   logic             load;
   scan_result_type  scan_result;
   scan_status_type  scan_status;
   queue_status_type queue_status;
   logic             head_valid;
   rsp_entry_type    head;

   assign req_item.ch       = req_chan.ch;
   assign req_item.is_final = req_chan.is_final;

   // The held character is consumed when it makes no entries, or when the
   // result queue can take all the entries it makes in this cycle.
   assign consume = held_valid && ((scan_result.count == 2'd0) || queue_status.load_ok);
   assign load    = consume && (scan_result.count != 2'd0);

   clt_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_item   (req_item),
      .req_ready  (req_chan.ready),
      .advance    (consume),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   // The scanner keeps the position, the entry count and the separator run
   // flags, and works out the entries of the held character combinationally.
   clt_scan #(
      .LINE_MAX (LINE_MAX)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (consume),
      .item    (held_item),
      .result  (scan_result),
      .status  (scan_status)
   );

   // The result queue holds the one or two entries of a character and hands
   // them out in order.
   clt_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (scan_result),
      .rsp_ready  (rsp_chan.ready),
      .head_valid (head_valid),
      .head       (head),
      .status     (queue_status)
   );

   assign rsp_chan.valid      = head_valid;
   assign rsp_chan.entry_kind = head.entry_kind;
   assign rsp_chan.position   = head.position;
   assign rsp_chan.slot       = head.slot;
   assign rsp_chan.run_end    = head.run_end;

   // An entry that is not the last of its character always has its partner
   // waiting behind it in the queue.
   `CLT_ASSERT_SAME(a_partner_queued, clock, reset,
      head_valid && !head.run_end, queue_status.count == 2'd2,
      "entry without run_end has no following entry queued")

   // After a transaction that is not the last of its character, the next
   // entry of the same character is on the port in the following cycle.
   `CLT_ASSERT_NEXT(a_partner_follows, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_end, rsp_chan.valid,
      "second entry of a character did not follow")

   // Consuming the last character of a line puts the scanner back at the
   // start of a new line.
   `CLT_ASSERT_NEXT(a_line_restart, clock, reset,
      consume && scan_result.line_done, scan_status.line_start,
      "scanner did not return to line start after end of line")

endmodule
